// ----- hw/rtl/bba_pkg.sv -----
// Shared constants of the buddy block allocator.
`default_nettype none
package bba_pkg;

  localparam int unsigned DefPoolOrder   = 16;
  localparam int unsigned DefMinOrder    = 5;
  localparam int unsigned DefHeaderBytes = 24;

  localparam int unsigned ReqW  = 32;
  localparam int unsigned AddrW = 16;
  // Wide enough for a request plus its header, and for the pool size itself.
  localparam int unsigned WideW = ReqW + 1;

  localparam logic FldSucc = 1'b0;
  localparam logic FldPred = 1'b1;

endpackage
`default_nettype wire

// ----- hw/rtl/bba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/buddy_block_allocator.sv -----
// Buddy block allocator: top level with the header RAM and its sequencer.
// Words are handled one at a time; every header access is a single RAM read or write, and a
// field update of a neighbor in a free list is a read followed by a write. An allocation takes
// the word and checks the size, searches for the needed order k, searches the free lists from
// order k upward, splits the block found down to order k, then takes the final block and hands
// over the result; an oversized request ends after the size check. A free checks the address
// and the header, merges with free buddies, then joins its list and hands over the result; a
// refused free ends after the check. Results leave through an output register, so the next
// word is taken while the previous result is still unclaimed; a further result then waits in
// the sequencer until that register is free. After reset the block writes the header of the
// whole pool before it takes its first word.
`default_nettype none
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned POOL_ORDER   = DefPoolOrder,
  parameter int unsigned MIN_ORDER    = DefMinOrder,
  parameter int unsigned HEADER_BYTES = DefHeaderBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,  // request_bytes[31:0], release_address[47:32]
  input  wire logic        s_axis_tuser_i,  // mode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // data_address[15:0]
  output logic             m_axis_tuser_o   // ok
);

  localparam int unsigned BlkW      = POOL_ORDER - MIN_ORDER;
  localparam int unsigned NumBlocks = 1 << BlkW;
  localparam int unsigned NumOrders = BlkW + 1;
  localparam int unsigned OrdW      = $clog2(POOL_ORDER + 2);
  localparam int unsigned LiW       = $clog2(NumOrders);
  localparam int unsigned HdrW      = 1 + OrdW + 2 * BlkW;

  localparam logic [OrdW-1:0]  PoolOrd = OrdW'(POOL_ORDER);
  localparam logic [OrdW-1:0]  MinOrd  = OrdW'(MIN_ORDER);
  localparam logic [WideW-1:0] HdrB    = WideW'(HEADER_BYTES);
  localparam logic [WideW-1:0] PoolB   = WideW'(1) << POOL_ORDER;

  typedef struct packed {
    logic            res;
    logic [OrdW-1:0] ord;
    logic [BlkW-1:0] succ;
    logic [BlkW-1:0] pred;
  } hdr_t;

  localparam logic [4:0] S_INIT  = 5'd0,  S_IDLE = 5'd1,  S_ALOC0 = 5'd2,  S_ORD  = 5'd3,
                         S_FIND  = 5'd4,  S_SPLIT = 5'd5, S_SPL1 = 5'd6,   S_SPL2 = 5'd7,
                         S_SPL3  = 5'd8,  S_SPL4 = 5'd9,  S_SPL5 = 5'd10,  S_SPL6 = 5'd11,
                         S_SPL7  = 5'd12, S_FIN  = 5'd13, S_FCHK = 5'd14,  S_F1   = 5'd15,
                         S_FM0   = 5'd16, S_FM1  = 5'd17, S_FM2  = 5'd18,  S_FM3  = 5'd19,
                         S_FJ    = 5'd20, S_FJ1  = 5'd21, S_FJ2  = 5'd22,  S_FJ3  = 5'd23,
                         S_UL0   = 5'd24, S_UL1  = 5'd25, S_UL2  = 5'd26,  S_FURD = 5'd27,
                         S_FUWR  = 5'd28, S_DONE = 5'd29;

  logic [4:0]       state_q, fu_ret_q, ul_ret_q;
  logic [ReqW-1:0]  req_q;
  logic [AddrW-1:0] addr_q;
  logic [OrdW-1:0]  k_q, i_q;
  logic [BlkW-1:0]  p_q, q_q, r_q, rp_q, u_q, fu_addr_q, fu_val_q;
  logic             fu_fld_q;
  hdr_t             hdr_q;
  logic             res_ok_q;
  logic [AddrW-1:0] res_addr_q;
  logic             out_valid_q, out_ok_q;
  logic [AddrW-1:0] out_addr_q;
  logic             head_vld_q [NumOrders];
  logic [BlkW-1:0]  head_blk_q [NumOrders];

  logic             ram_we;
  logic [BlkW-1:0]  ram_waddr, ram_raddr;
  hdr_t             ram_wdata, ram_rdata, fu_mod;
  logic [HdrW-1:0]  ram_rdata_raw;

  logic [LiW-1:0]   li;
  logic             i_in_range, head_v;
  logic [BlkW-1:0]  head_b;
  logic [WideW-1:0] need, off, blk_off;
  logic             free_bad;
  logic [BlkW-1:0]  free_p, buddy;
  logic             out_load;

  bba_ram #(.Width(HdrW), .Depth(NumBlocks)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );
  assign ram_rdata = hdr_t'(ram_rdata_raw);

  assign li         = LiW'(i_q - MinOrd);
  assign i_in_range = (i_q <= PoolOrd);
  assign head_v     = i_in_range && head_vld_q[li];
  assign head_b     = head_blk_q[li];

  assign need     = WideW'(req_q) + HdrB;
  assign off      = WideW'(addr_q) - HdrB;
  assign free_bad = (WideW'(addr_q) < HdrB) || (off[MIN_ORDER-1:0] != '0) || (off >= PoolB);
  assign free_p   = off[MIN_ORDER +: BlkW];
  assign buddy    = p_q ^ (BlkW'(1) << (i_q - MinOrd));
  assign blk_off  = (WideW'(p_q) << MIN_ORDER) + HdrB;

  // The finished result moves to the output register once that register is free.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    fu_mod = ram_rdata;
    if (fu_fld_q == FldSucc) begin
      fu_mod.succ = fu_val_q;
    end else begin
      fu_mod.pred = fu_val_q;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_q;
    ram_wdata = '{res: 1'b0, ord: i_q, succ: p_q, pred: p_q};
    ram_raddr = p_q;
    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{res: 1'b0, ord: PoolOrd, succ: '0, pred: '0};
      end
      S_UL0:  ram_raddr = u_q;
      S_FURD: ram_raddr = fu_addr_q;
      S_FUWR: begin
        ram_we    = 1'b1;
        ram_waddr = fu_addr_q;
        ram_wdata = fu_mod;
      end
      S_SPL2: ram_raddr = head_b;
      S_SPL3: begin
        ram_we    = 1'b1;
        ram_wdata = '{res: 1'b0, ord: i_q, succ: q_q, pred: ram_rdata.pred};
      end
      S_SPL4: begin
        ram_we    = 1'b1;
        ram_wdata = '{res: 1'b0, ord: i_q, succ: q_q, pred: q_q};
      end
      S_SPL5: begin
        ram_we    = 1'b1;
        ram_waddr = q_q;
        ram_wdata = '{res: 1'b0, ord: i_q, succ: head_v ? r_q : p_q, pred: p_q};
      end
      S_FIN: begin
        ram_we    = 1'b1;
        ram_wdata = '{res: 1'b1, ord: i_q, succ: p_q, pred: p_q};
      end
      S_FCHK: ram_raddr = free_p;
      S_F1: begin
        ram_we        = ram_rdata.res && (ram_rdata.ord >= MinOrd) && (ram_rdata.ord <= PoolOrd);
        ram_wdata     = ram_rdata;
        ram_wdata.res = 1'b0;
      end
      S_FM0: ram_raddr = buddy;
      S_FM3: ram_we = 1'b1;
      S_FJ:  ram_raddr = head_b;
      S_FJ1: begin
        ram_we    = 1'b1;
        ram_wdata = '{res: 1'b0, ord: i_q, succ: r_q, pred: ram_rdata.pred};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
      for (int n = 0; n < NumOrders; n++) begin
        head_vld_q[n] <= (n == NumOrders - 1);
        head_blk_q[n] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: state_q <= S_IDLE;
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            req_q    <= s_axis_tdata_i[31:0];
            addr_q   <= s_axis_tdata_i[47:32];
            res_ok_q   <= 1'b0;
            res_addr_q <= '0;
            state_q  <= s_axis_tuser_i ? S_FCHK : S_ALOC0;
          end
        end
        S_ALOC0: begin
          k_q     <= MinOrd;
          state_q <= (need > PoolB) ? S_DONE : S_ORD;
        end
        S_ORD: begin
          if ((k_q < PoolOrd) && ((WideW'(1) << k_q) < need)) begin
            k_q <= k_q + 1'b1;
          end else begin
            i_q     <= k_q;
            state_q <= S_FIND;
          end
        end
        S_FIND: begin
          if (!i_in_range) begin
            state_q <= S_DONE;
          end else if (head_v) begin
            p_q     <= head_b;
            state_q <= S_SPLIT;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_SPLIT: begin
          u_q      <= p_q;
          ul_ret_q <= (i_q > k_q) ? S_SPL1 : S_FIN;
          state_q  <= S_UL0;
        end
        S_SPL1: begin
          i_q     <= i_q - 1'b1;
          q_q     <= p_q + (BlkW'(1) << (i_q - 1'b1 - MinOrd));
          state_q <= S_SPL2;
        end
        S_SPL2: begin
          r_q     <= head_b;
          state_q <= head_v ? S_SPL3 : S_SPL4;
        end
        S_SPL3: begin
          rp_q    <= ram_rdata.pred;
          state_q <= S_SPL5;
        end
        S_SPL4: state_q <= S_SPL5;
        S_SPL5: begin
          if (head_v) begin
            fu_addr_q <= rp_q;
            fu_fld_q  <= FldSucc;
            fu_val_q  <= p_q;
            fu_ret_q  <= S_SPL7;
            state_q   <= S_FURD;
          end else begin
            state_q <= S_SPL6;
          end
        end
        S_SPL7: begin
          fu_addr_q <= r_q;
          fu_fld_q  <= FldPred;
          fu_val_q  <= q_q;
          fu_ret_q  <= S_SPL6;
          state_q   <= S_FURD;
        end
        S_SPL6: begin
          head_vld_q[li] <= 1'b1;
          head_blk_q[li] <= p_q;
          state_q        <= S_SPLIT;
        end
        S_FIN: begin
          res_ok_q   <= 1'b1;
          res_addr_q <= blk_off[AddrW-1:0];
          state_q    <= S_DONE;
        end
        S_FCHK: begin
          p_q     <= free_p;
          state_q <= free_bad ? S_DONE : S_F1;
        end
        S_F1: begin
          if (ram_rdata.res && (ram_rdata.ord >= MinOrd) && (ram_rdata.ord <= PoolOrd)) begin
            i_q     <= ram_rdata.ord;
            state_q <= S_FM0;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_FM0: begin
          q_q     <= buddy;
          state_q <= (i_q < PoolOrd) ? S_FM1 : S_FJ;
        end
        S_FM1: begin
          if (ram_rdata.res || (ram_rdata.ord != i_q)) begin
            state_q <= S_FJ;
          end else begin
            u_q      <= q_q;
            ul_ret_q <= S_FM2;
            state_q  <= S_UL0;
          end
        end
        S_FM2: begin
          if (q_q < p_q) begin
            p_q <= q_q;
          end
          i_q     <= i_q + 1'b1;
          state_q <= S_FM3;
        end
        S_FM3: state_q <= S_FM0;
        S_FJ: begin
          r_q     <= head_b;
          state_q <= head_v ? S_FJ1 : S_FJ3;
        end
        S_FJ1: begin
          fu_addr_q <= ram_rdata.pred;
          fu_fld_q  <= FldSucc;
          fu_val_q  <= p_q;
          fu_ret_q  <= S_FJ2;
          state_q   <= S_FURD;
        end
        S_FJ2: begin
          fu_addr_q <= r_q;
          fu_fld_q  <= FldPred;
          fu_val_q  <= p_q;
          fu_ret_q  <= S_FJ3;
          state_q   <= S_FURD;
        end
        S_FJ3: begin
          head_vld_q[li] <= 1'b1;
          head_blk_q[li] <= p_q;
          res_ok_q       <= 1'b1;
          res_addr_q     <= '0;
          state_q        <= S_DONE;
        end
        S_UL0: state_q <= S_UL1;
        S_UL1: begin
          hdr_q <= ram_rdata;
          if (ram_rdata.succ == u_q) begin
            head_vld_q[li] <= 1'b0;
            head_blk_q[li] <= '0;
            state_q        <= ul_ret_q;
          end else begin
            head_vld_q[li] <= 1'b1;
            head_blk_q[li] <= ram_rdata.succ;
            fu_addr_q      <= ram_rdata.pred;
            fu_fld_q       <= FldSucc;
            fu_val_q       <= ram_rdata.succ;
            fu_ret_q       <= S_UL2;
            state_q        <= S_FURD;
          end
        end
        S_UL2: begin
          fu_addr_q <= hdr_q.succ;
          fu_fld_q  <= FldPred;
          fu_val_q  <= hdr_q.pred;
          fu_ret_q  <= ul_ret_q;
          state_q   <= S_FURD;
        end
        S_FURD: state_q <= S_FUWR;
        S_FUWR: state_q <= fu_ret_q;
        S_DONE: begin
          if (out_load) begin
            out_ok_q    <= res_ok_q;
            out_addr_q  <= res_addr_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_addr_q;
  assign m_axis_tuser_o  = out_ok_q;

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the buddy block allocator.
`default_nettype none
module testbench
  import bba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PoolOrder = DefPoolOrder;
  localparam int unsigned MinOrder  = DefMinOrder;
  localparam int unsigned HdrBytes  = DefHeaderBytes;
  localparam int unsigned NumBlocks = 1 << (PoolOrder - MinOrder);
  localparam int unsigned NumOrders = PoolOrder - MinOrder + 1;
  localparam int unsigned BlkMask   = NumBlocks - 1;

  typedef enum logic { ModeAlloc = 1'b0, ModeFree = 1'b1 } mode_e;

  typedef struct packed {
    logic        ok;
    logic [15:0] addr;
  } result_t;

  typedef struct {
    bit          reserved;
    int unsigned order;
    int unsigned succ;
    int unsigned pred;
  } hdr_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;  // request_bytes[31:0], release_address[47:32]
  logic        s_axis_tuser_i;  // mode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;  // data_address[15:0]
  logic        m_axis_tuser_o;  // ok

  buddy_block_allocator u_dut (.*);

  // Predictor state.
  bit          head_valid[NumOrders];
  int unsigned head_blk[NumOrders];
  hdr_t        hdrs[NumBlocks];
  bit          hdr_written[NumBlocks];
  result_t     pending_results[$];
  logic [15:0] live_addrs[$];
  int          n_errors;
  bit          rx_idle_en;
  bit          tx_idle_en;
  int          rx_hold;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void model_reset();
    for (int i = 0; i < NumOrders; i++) begin
      head_valid[i] = 0;
      head_blk[i]   = 0;
    end
    for (int i = 0; i < NumBlocks; i++) begin
      hdrs[i]        = '{0, 0, 0, 0};
      hdr_written[i] = 0;
    end
    hdrs[0] = '{0, PoolOrder, 0, 0};
    hdr_written[0] = 1;
    head_valid[NumOrders-1] = 1;
  endfunction

  function automatic void list_unlink(int unsigned li, int unsigned p);
    int unsigned s;
    int unsigned r;
    s = hdrs[p].succ & BlkMask;
    r = hdrs[p].pred & BlkMask;
    if (s == p) begin
      head_valid[li] = 0;
      head_blk[li]   = 0;
    end else begin
      hdrs[r].succ   = s;
      hdrs[s].pred   = r;
      head_valid[li] = 1;
      head_blk[li]   = s;
    end
  endfunction

  // Puts block p at the tail of list li, p becoming its head.
  function automatic void list_insert_head(int unsigned li, int unsigned p);
    int unsigned q;
    int unsigned qp;
    if (head_valid[li]) begin
      q  = head_blk[li];
      qp = hdrs[q].pred;
      hdrs[p].pred  = qp;
      hdrs[p].succ  = q;
      hdrs[qp].succ = p;
      hdrs[q].pred  = p;
    end
    head_valid[li] = 1;
    head_blk[li]   = p;
  endfunction

  function automatic result_t predict_alloc(logic [31:0] req);
    longint unsigned need;
    int unsigned k;
    int unsigned i;
    int unsigned p;
    int unsigned q;
    need = longint'(req) + HdrBytes;
    if (need > (64'd1 << PoolOrder)) return '0;
    k = 0;
    while (k < PoolOrder && (64'd1 << k) < need) k++;
    if (k < MinOrder) k = MinOrder;
    i = k;
    while (i <= PoolOrder && !head_valid[i-MinOrder]) i++;
    if (i > PoolOrder) return '0;
    p = head_blk[i-MinOrder];
    while (i > k) begin
      list_unlink(i - MinOrder, p);
      i--;
      q = (p + (1 << (i - MinOrder))) & BlkMask;
      hdrs[p] = '{hdrs[p].reserved, i, q, q};
      hdrs[q] = '{0, i, p, p};
      hdr_written[q] = 1;
      if (head_valid[i-MinOrder]) begin
        hdrs[q].succ = head_blk[i-MinOrder];
        hdrs[p].pred = hdrs[head_blk[i-MinOrder]].pred;
        hdrs[hdrs[p].pred].succ = p;
        hdrs[head_blk[i-MinOrder]].pred = q;
      end
      head_valid[i-MinOrder] = 1;
      head_blk[i-MinOrder]   = p;
    end
    list_unlink(k - MinOrder, p);
    hdrs[p].reserved = 1;
    hdrs[p].succ = p;
    hdrs[p].pred = p;
    return '{1'b1, 16'((p << MinOrder) + HdrBytes)};
  endfunction

  function automatic result_t predict_free(logic [15:0] addr);
    int unsigned off;
    int unsigned p;
    int unsigned k;
    int unsigned q;
    if (addr < HdrBytes) return '0;
    off = addr - HdrBytes;
    if ((off & ((1 << MinOrder) - 1)) != 0 || off >= (1 << PoolOrder)) return '0;
    p = (off >> MinOrder) & BlkMask;
    k = hdrs[p].order;
    if (!hdrs[p].reserved || k < MinOrder || k > PoolOrder) return '0;
    hdrs[p].reserved = 0;
    while (k < PoolOrder) begin
      q = (p ^ (1 << (k - MinOrder))) & BlkMask;
      if (hdrs[q].reserved || hdrs[q].order != k) break;
      list_unlink(k - MinOrder, q);
      if (q < p) p = q;
      k++;
      hdrs[p].order = k;
      hdrs[p].succ  = p;
      hdrs[p].pred  = p;
    end
    hdrs[p].reserved = 0;
    list_insert_head(k - MinOrder, p);
    return '{1'b1, 16'h0};
  endfunction

  // Sends one word and records the expected result once it is taken. The word stays offered
  // until the next call or a drain replaces or withdraws it.
  task automatic send_word(mode_e mode, logic [31:0] req, logic [15:0] addr);
    result_t r;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= {addr, req};
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = (mode == ModeAlloc) ? predict_alloc(req) : predict_free(addr);
    pending_results.push_back(r);
    if (mode == ModeAlloc && r.ok) live_addrs.push_back(r.addr);
    @(negedge clk_i);
  endtask

  task automatic alloc_word(logic [31:0] req);
    send_word(ModeAlloc, req, 16'($urandom));
  endtask

  // Frees a live block chosen at random, or a random address. A random address that would
  // name a header slot never written is moved to the first block.
  task automatic free_word(bit live);
    int idx;
    logic [15:0] a;
    if (live && live_addrs.size() > 0) begin
      idx = $urandom_range(0, live_addrs.size() - 1);
      a = live_addrs[idx];
      live_addrs.delete(idx);
    end else begin
      a = 16'($urandom);
      if (a >= HdrBytes && ((a - HdrBytes) & ((1 << MinOrder) - 1)) == 0
          && !hdr_written[((a - HdrBytes) >> MinOrder) & BlkMask]) begin
        a = 16'(HdrBytes);
      end
    end
    send_word(ModeFree, 32'($urandom), a);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() > 0);
  endtask

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: ok=%0b data_address=%h",
               m_axis_tuser_o, m_axis_tdata_o);
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tuser_o !== exp_r.ok) begin
          $error("ok: expected %0b, got %0b", exp_r.ok, m_axis_tuser_o);
          n_errors++;
        end
        if (m_axis_tdata_o !== exp_r.addr) begin
          $error("data_address: expected %h, got %h", exp_r.addr, m_axis_tdata_o);
          n_errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      rx_hold = $urandom_range(0, 5);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic test_directed();
    alloc_word(32'd0);
    alloc_word(32'd8);
    alloc_word(32'd40);
    alloc_word(32'hFFFF_FFFF);
    alloc_word(32'd65512);
    alloc_word(32'd65513);
    alloc_word(32'd1000);
    send_word(ModeFree, 32'd0, 16'd0);
    send_word(ModeFree, 32'd0, 16'd25);
    send_word(ModeFree, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(ModeFree, 32'd0, 16'd24);
    send_word(ModeFree, 32'd0, 16'd24);
    // Free everything so the pool merges back to one block.
    while (live_addrs.size() > 0) free_word(1);
    alloc_word(32'd65512);
    alloc_word(32'd0);
    free_word(1);
    // A few more minimum-size blocks.
    for (int i = 0; i < 6; i++) alloc_word(32'd8);
  endtask

  task automatic test_random(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        case ($urandom_range(0, 3))
          0: alloc_word(32'($urandom_range(0, 40)));
          1: alloc_word(32'($urandom_range(0, 1000)));
          2: alloc_word(32'($urandom_range(0, 70000)));
          default: alloc_word(32'($urandom));
        endcase
      end else if (sel < 90) begin
        free_word(1);
      end else begin
        free_word(0);
      end
    end
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    for (int i = 0; i < 20; i++) alloc_word(32'($urandom_range(0, 200)));
    drain();
    for (int i = 0; i < 20; i++) free_word(1);
    drain();
  endtask

  initial begin
    int cyc;
    n_errors = 0;
    rx_idle_en = 1;
    tx_idle_en = 1;
    rx_hold = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    m_axis_tready_i = 1'b0;
    model_reset();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(600);
    test_backpressure();
    test_random(500);
    drain();
    rx_idle_en = 0;
    tx_idle_en = 0;
    // Let any receiver hold that is still running run out.
    repeat (8) @(negedge clk_i);
    test_random(150);
    drain();
    cyc = 0;
    while (cyc < 400) begin
      @(negedge clk_i);
      cyc++;
    end
    if (n_errors == 0) $display("buddy_block_allocator regression: pass");
    else $display("buddy_block_allocator regression: fail");
    $finish;
  end

  initial begin
    #10000000;
    $display("buddy_block_allocator regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
